// ----- rtl/core/ghp_pkg.sv -----
// Shared definitions for the generational handle pool.
// Holds operation codes, parameter defaults and the memory enable struct.
// No dependencies.
package ghp_pkg;

  // Parameter defaults
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int GEN_BITS_DEF  = 16;

  // Operation codes carried on mode
  localparam logic [2:0] MODE_CREATE  = 3'd0;
  localparam logic [2:0] MODE_DESTROY = 3'd1;
  localparam logic [2:0] MODE_LOOKUP  = 3'd2;
  localparam logic [2:0] MODE_KILL    = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;
  localparam logic [2:0] MODE_READ    = 3'd5;

  // Write and read enables of one memory port pair
  typedef struct packed {
    logic we;
    logic re;
  } ghp_mem_ctl_t;

endpackage

// ----- rtl/core/generational_handle_pool.sv -----
// Generational handle pool. A fresh create or a request rejected on its fields is
// answered from idle; lookup or a failed handle or slot check reads the slot word;
// create from the free stack and read active read the list first; destroy and kill
// move the last entry and free the slot; clear sweeps each allocated slot. The next
// item is taken in the done cycle. Synchronous reset empties the pool at once; memories
// are not swept, since the allocated-slot count masks every entry that was never written.
module generational_handle_pool #(
  parameter int MAX_SLOTS = ghp_pkg::MAX_SLOTS_DEF,
  parameter int GEN_BITS  = ghp_pkg::GEN_BITS_DEF,
  localparam int SLOT_W   = $clog2(MAX_SLOTS),
  localparam int ID_W     = $clog2(MAX_SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          mode,
  input  logic [ID_W-1:0]     handle_id,
  input  logic [GEN_BITS-1:0] handle_gen,
  input  logic [SLOT_W-1:0]   slot_index,
  input  logic [SLOT_W-1:0]   list_position,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ID_W-1:0]     cfg_data,
  output logic                done,
  output logic                ok,
  output logic [ID_W-1:0]     out_id,
  output logic [GEN_BITS-1:0] out_gen,
  output logic [ID_W-1:0]     live_count
);
  import ghp_pkg::*;

  localparam int SW = 1 + GEN_BITS + SLOT_W;

  logic [ID_W-1:0]   max_units;
  ghp_mem_ctl_t      s_ctl;
  logic [SLOT_W-1:0] s_waddr;
  logic [SW-1:0]     s_wdata;
  logic [SLOT_W-1:0] s_raddr;
  logic [SW-1:0]     s_rdata;
  ghp_mem_ctl_t      l_ctl;
  logic [SLOT_W-1:0] l_waddr;
  logic [SLOT_W-1:0] l_wdata;
  logic [SLOT_W-1:0] l_raddr;
  logic [SLOT_W-1:0] l_rdata;

  assign cfg_ready = 1'b1;

  // Capture the slot limit on each configuration beat
  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= ID_W'(MAX_SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      max_units <= cfg_data;
    end
  end

  ghp_seq #(
    .MAX_SLOTS (MAX_SLOTS),
    .GEN_BITS  (GEN_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .handle_id     (handle_id),
    .handle_gen    (handle_gen),
    .slot_index    (slot_index),
    .list_position (list_position),
    .max_units     (max_units),
    .s_ctl         (s_ctl),
    .s_waddr       (s_waddr),
    .s_wdata       (s_wdata),
    .s_raddr       (s_raddr),
    .s_rdata       (s_rdata),
    .l_ctl         (l_ctl),
    .l_waddr       (l_waddr),
    .l_wdata       (l_wdata),
    .l_raddr       (l_raddr),
    .l_rdata       (l_rdata),
    .done          (done),
    .ok            (ok),
    .out_id        (out_id),
    .out_gen       (out_gen),
    .live_count    (live_count)
  );

  // Per-slot word: occupied flag, generation, active list position
  ghp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .ctl   (s_ctl),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Active list from the bottom, free stack from the top
  ghp_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_list_ram (
    .clk   (clk),
    .ctl   (l_ctl),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

`ifndef NO_ASSERTIONS
  // A failed beat carries the null handle
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (out_id == '0) && (out_gen == '0))
    else $error("failed result carries a nonzero handle");

  // A handle that is handed out never has generation zero
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && ok && (out_id != '0)) |-> (out_gen != '0))
    else $error("handle with generation zero");

  // Every multi-cycle operation ends with a result beat
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("operation ended without a result beat");

  // A clear that completes at once leaves no live slot
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_CLEAR)) |=> busy || (done && ok && (live_count == '0)))
    else $error("clear left live slots");
`endif

endmodule

// ----- rtl/core/ghp_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Depends on ghp_pkg for the enable struct.
module ghp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  ghp_pkg::ghp_mem_ctl_t     ctl,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);
  import ghp_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word into the registered output
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/ghp_seq.sv -----
// Operation sequencer of the handle pool: counters, read-modify-write steps
// on the slot memory and the list memory, and the registered result beat.
// Depends on ghp_pkg; drives two ghp_ram instances in the top level.
module ghp_seq #(
  parameter int MAX_SLOTS = ghp_pkg::MAX_SLOTS_DEF,
  parameter int GEN_BITS  = ghp_pkg::GEN_BITS_DEF,
  localparam int SLOT_W   = $clog2(MAX_SLOTS),
  localparam int ID_W     = $clog2(MAX_SLOTS + 1),
  localparam int SW       = 1 + GEN_BITS + SLOT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            mode,
  input  logic [ID_W-1:0]       handle_id,
  input  logic [GEN_BITS-1:0]   handle_gen,
  input  logic [SLOT_W-1:0]     slot_index,
  input  logic [SLOT_W-1:0]     list_position,
  input  logic [ID_W-1:0]       max_units,
  output ghp_pkg::ghp_mem_ctl_t s_ctl,
  output logic [SLOT_W-1:0]     s_waddr,
  output logic [SW-1:0]         s_wdata,
  output logic [SLOT_W-1:0]     s_raddr,
  input  logic [SW-1:0]         s_rdata,
  output ghp_pkg::ghp_mem_ctl_t l_ctl,
  output logic [SLOT_W-1:0]     l_waddr,
  output logic [SLOT_W-1:0]     l_wdata,
  output logic [SLOT_W-1:0]     l_raddr,
  input  logic [SLOT_W-1:0]     l_rdata,
  output logic                  done,
  output logic                  ok,
  output logic [ID_W-1:0]       out_id,
  output logic [GEN_BITS-1:0]   out_gen,
  output logic [ID_W-1:0]       live_count
);
  import ghp_pkg::*;

  localparam logic [ID_W-1:0] MAX_ID = ID_W'(MAX_SLOTS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_POP    = 4'd1;
  localparam logic [3:0] ST_CREATE = 4'd2;
  localparam logic [3:0] ST_FETCH  = 4'd3;
  localparam logic [3:0] ST_RDGEN  = 4'd4;
  localparam logic [3:0] ST_CHECK  = 4'd5;
  localparam logic [3:0] ST_LAST   = 4'd6;
  localparam logic [3:0] ST_MOVE   = 4'd7;
  localparam logic [3:0] ST_FREE   = 4'd8;
  localparam logic [3:0] ST_SWEEP  = 4'd9;

  // Control registers
  logic [3:0]          state, state_next;
  logic [ID_W-1:0]     sa, sa_next;       // slots ever allocated
  logic [ID_W-1:0]     ft, ft_next;       // free stack depth
  logic [ID_W-1:0]     ac, ac_next;       // active list length
  logic [ID_W-1:0]     cnt, cnt_next;     // clear sweep read pointer
  logic                done_next;

  // Payload registers of the item at work
  logic [2:0]          op, op_next;
  logic [GEN_BITS-1:0] hgen, hgen_next;
  logic [SLOT_W-1:0]   slot, slot_next;
  logic [SLOT_W-1:0]   pos, pos_next;
  logic [GEN_BITS-1:0] gen, gen_next;
  logic [SLOT_W-1:0]   last, last_next;
  logic                ok_next;
  logic [ID_W-1:0]     out_id_next;
  logic [GEN_BITS-1:0] out_gen_next;
  logic [ID_W-1:0]     live_count_next;

  // Fields of the slot word read back from memory
  logic                rd_occ;
  logic [GEN_BITS-1:0] rd_gen;
  logic [SLOT_W-1:0]   rd_pos;
  logic [ID_W-1:0]     hid_slot;
  logic [ID_W-1:0]     wi;
  logic                valid;

  assign rd_occ   = s_rdata[SW-1];
  assign rd_gen   = s_rdata[SLOT_W +: GEN_BITS];
  assign rd_pos   = s_rdata[SLOT_W-1:0];
  assign hid_slot = handle_id - 1'b1;
  assign wi       = cnt - 1'b1;
  assign valid    = rd_occ && ((op == MODE_KILL) || (rd_gen == hgen));
  assign busy     = (state != ST_IDLE);

  // Advance a generation, skipping zero on wrap
  function automatic logic [GEN_BITS-1:0] next_gen(input logic [GEN_BITS-1:0] g);
    logic [GEN_BITS-1:0] n;
    n = g + 1'b1;
    return (n == '0) ? GEN_BITS'(1) : n;
  endfunction

  // Step logic: memory requests, counter updates and result beat
  always_comb begin
    state_next   = state;
    sa_next      = sa;
    ft_next      = ft;
    ac_next      = ac;
    cnt_next     = cnt;
    op_next      = op;
    hgen_next    = hgen;
    slot_next    = slot;
    pos_next     = pos;
    gen_next     = gen;
    last_next    = last;
    done_next    = 1'b0;
    ok_next      = ok;
    out_id_next  = out_id;
    out_gen_next = out_gen;
    s_ctl        = '0;
    s_waddr      = '0;
    s_wdata      = '0;
    s_raddr      = '0;
    l_ctl        = '0;
    l_waddr      = '0;
    l_wdata      = '0;
    l_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next   = mode;
          hgen_next = handle_gen;
          case (mode)
            MODE_CREATE: begin
              if (ft != '0) begin
                // pop the free stack, which grows down from the top of the list
                l_ctl.re   = 1'b1;
                l_raddr    = SLOT_W'(MAX_ID - ft);
                state_next = ST_POP;
              end else if ((sa < max_units) && (sa < MAX_ID)) begin
                // take a fresh slot
                s_ctl.we     = 1'b1;
                s_waddr      = SLOT_W'(sa);
                s_wdata      = {1'b1, GEN_BITS'(1), SLOT_W'(ac)};
                l_ctl.we     = 1'b1;
                l_waddr      = SLOT_W'(ac);
                l_wdata      = SLOT_W'(sa);
                ac_next      = ac + 1'b1;
                sa_next      = sa + 1'b1;
                done_next    = 1'b1;
                ok_next      = 1'b1;
                out_id_next  = sa + 1'b1;
                out_gen_next = GEN_BITS'(1);
              end else begin
                done_next    = 1'b1;
                ok_next      = 1'b0;
                out_id_next  = '0;
                out_gen_next = '0;
              end
            end
            MODE_DESTROY, MODE_LOOKUP: begin
              if ((handle_id != '0) && (hid_slot < sa)) begin
                s_ctl.re   = 1'b1;
                s_raddr    = SLOT_W'(hid_slot);
                slot_next  = SLOT_W'(hid_slot);
                state_next = ST_CHECK;
              end else begin
                done_next    = 1'b1;
                ok_next      = 1'b0;
                out_id_next  = '0;
                out_gen_next = '0;
              end
            end
            MODE_KILL: begin
              if (ID_W'(slot_index) < sa) begin
                s_ctl.re   = 1'b1;
                s_raddr    = slot_index;
                slot_next  = slot_index;
                state_next = ST_CHECK;
              end else begin
                done_next    = 1'b1;
                ok_next      = 1'b0;
                out_id_next  = '0;
                out_gen_next = '0;
              end
            end
            MODE_CLEAR: begin
              ac_next = '0;
              ft_next = '0;
              if (sa == '0) begin
                done_next    = 1'b1;
                ok_next      = 1'b1;
                out_id_next  = '0;
                out_gen_next = '0;
              end else begin
                s_ctl.re   = 1'b1;
                s_raddr    = '0;
                cnt_next   = ID_W'(1);
                state_next = ST_SWEEP;
              end
            end
            MODE_READ: begin
              if (ID_W'(list_position) < ac) begin
                l_ctl.re   = 1'b1;
                l_raddr    = list_position;
                state_next = ST_FETCH;
              end else begin
                done_next    = 1'b1;
                ok_next      = 1'b0;
                out_id_next  = '0;
                out_gen_next = '0;
              end
            end
            default: begin
              done_next    = 1'b1;
              ok_next      = 1'b0;
              out_id_next  = '0;
              out_gen_next = '0;
            end
          endcase
        end
      end

      // Popped slot is known: fetch its word
      ST_POP: begin
        slot_next  = l_rdata;
        s_ctl.re   = 1'b1;
        s_raddr    = l_rdata;
        ft_next    = ft - 1'b1;
        state_next = ST_CREATE;
      end

      // Mark the popped slot live and append it to the active list, unless it is occupied
      ST_CREATE: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (!rd_occ) begin
          s_ctl.we     = 1'b1;
          s_waddr      = slot;
          s_wdata      = {1'b1, rd_gen, SLOT_W'(ac)};
          l_ctl.we     = 1'b1;
          l_waddr      = SLOT_W'(ac);
          l_wdata      = slot;
          ac_next      = ac + 1'b1;
          ok_next      = 1'b1;
          out_id_next  = ID_W'(slot) + 1'b1;
          out_gen_next = rd_gen;
        end else begin
          ok_next      = 1'b0;
          out_id_next  = '0;
          out_gen_next = '0;
        end
      end

      // Active list entry is known: fetch the slot word for its generation
      ST_FETCH: begin
        slot_next  = l_rdata;
        s_ctl.re   = 1'b1;
        s_raddr    = l_rdata;
        state_next = ST_RDGEN;
      end

      ST_RDGEN: begin
        done_next    = 1'b1;
        ok_next      = 1'b1;
        out_id_next  = ID_W'(slot) + 1'b1;
        out_gen_next = rd_gen;
        state_next   = ST_IDLE;
      end

      // Validate the handle or slot; a lookup ends here, else start the release
      ST_CHECK: begin
        gen_next = rd_gen;
        pos_next = rd_pos;
        if (!valid) begin
          done_next    = 1'b1;
          ok_next      = 1'b0;
          out_id_next  = '0;
          out_gen_next = '0;
          state_next   = ST_IDLE;
        end else if (op == MODE_LOOKUP) begin
          done_next    = 1'b1;
          ok_next      = 1'b1;
          out_id_next  = '0;
          out_gen_next = '0;
          state_next   = ST_IDLE;
        end else if ((ac != '0) && (ID_W'(rd_pos) < ac)) begin
          l_ctl.re   = 1'b1;
          l_raddr    = SLOT_W'(ac - 1'b1);
          state_next = ST_LAST;
        end else begin
          state_next = ST_FREE;
        end
      end

      // Move the last active entry into the hole
      ST_LAST: begin
        last_next  = l_rdata;
        l_ctl.we   = 1'b1;
        l_waddr    = pos;
        l_wdata    = l_rdata;
        s_ctl.re   = 1'b1;
        s_raddr    = l_rdata;
        state_next = ST_MOVE;
      end

      // Update the moved slot's list position and shrink the list
      ST_MOVE: begin
        if (last != slot) begin
          s_ctl.we = 1'b1;
          s_waddr  = last;
          s_wdata  = {rd_occ, rd_gen, pos};
        end
        ac_next    = ac - 1'b1;
        state_next = ST_FREE;
      end

      // Free the slot, advance its generation, push it on the free stack if it has room
      ST_FREE: begin
        s_ctl.we = 1'b1;
        s_waddr  = slot;
        s_wdata  = {1'b0, next_gen(gen), pos};
        if (ft < MAX_ID) begin
          l_ctl.we = 1'b1;
          l_waddr  = SLOT_W'(MAX_ID - ft - 1'b1);
          l_wdata  = slot;
          ft_next  = ft + 1'b1;
        end
        done_next = 1'b1;
        ok_next   = 1'b1;
        if (op == MODE_KILL) begin
          out_id_next  = ID_W'(slot) + 1'b1;
          out_gen_next = gen;
        end else begin
          out_id_next  = '0;
          out_gen_next = '0;
        end
        state_next = ST_IDLE;
      end

      // Clear: free one allocated slot per cycle in ascending order
      ST_SWEEP: begin
        s_ctl.we = 1'b1;
        s_waddr  = SLOT_W'(wi);
        s_wdata  = {1'b0, next_gen(rd_gen), SLOT_W'(0)};
        l_ctl.we = 1'b1;
        l_waddr  = SLOT_W'(MAX_ID - cnt);
        l_wdata  = SLOT_W'(wi);
        if (cnt < sa) begin
          s_ctl.re = 1'b1;
          s_raddr  = SLOT_W'(cnt);
          cnt_next = cnt + 1'b1;
        end else begin
          ft_next      = sa;
          done_next    = 1'b1;
          ok_next      = 1'b1;
          out_id_next  = '0;
          out_gen_next = '0;
          state_next   = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    live_count_next = done_next ? ac_next : live_count;
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sa    <= '0;
      ft    <= '0;
      ac    <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      sa    <= sa_next;
      ft    <= ft_next;
      ac    <= ac_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op         <= op_next;
    hgen       <= hgen_next;
    slot       <= slot_next;
    pos        <= pos_next;
    gen        <= gen_next;
    last       <= last_next;
    ok         <= ok_next;
    out_id     <= out_id_next;
    out_gen    <= out_gen_next;
    live_count <= live_count_next;
  end

endmodule
